// ===== design/text_stream_visualizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text stream visualizer
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_STREAM_VISUALIZER_ASSERT_SVH
`define TEXT_STREAM_VISUALIZER_ASSERT_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define TSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define TSV_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define TSV_ASSERT(lbl, prop, msg)
`define TSV_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== design/tsv_pkg.sv =====
// ----------------------------------------------------------------------------
// Text stream visualizer package
// Shared constants, register codes and the types passed between the parts.
// ----------------------------------------------------------------------------
`default_nettype none

package tsv_pkg;

  // Width of a printed line number in decimal digits.
  localparam int unsigned NumDigits    = 6;
  localparam int unsigned BcdW         = 4 * NumDigits;
  // The line counter never goes beyond what this many binary bits hold.
  localparam int unsigned CountMaxBits = 20;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Position inside a segment: digits plus tab, or up to four glyph bytes.
  localparam int unsigned IdxW = ($clog2(NumDigits + 1) > 2) ? $clog2(NumDigits + 1) : 2;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUMBER_MODE      = 3'd0,
    REG_SHOW_ENDS        = 3'd1,
    REG_SHOW_TABS        = 3'd2,
    REG_SHOW_NONPRINTING = 3'd3,
    REG_SQUEEZE_BLANK    = 3'd4
  } cfg_reg_e;

  localparam logic [1:0] NumModeOff = 2'd0;
  localparam logic [1:0] NumModeAll = 2'd1;

  localparam logic [1:0] RunMax = 2'd3;

  localparam logic [7:0] ByteTab      = 8'h09;
  localparam logic [7:0] ByteNewline  = 8'h0A;
  localparam logic [7:0] ByteSpace    = 8'h20;
  localparam logic [7:0] ByteDollar   = 8'h24;
  localparam logic [7:0] ByteDash     = 8'h2D;
  localparam logic [7:0] ByteZero     = 8'h30;
  localparam logic [7:0] ByteQuestion = 8'h3F;
  localparam logic [7:0] ByteI        = 8'h49;
  localparam logic [7:0] ByteM        = 8'h4D;
  localparam logic [7:0] ByteCaret    = 8'h5E;
  localparam logic [7:0] ByteCtrlEnd  = 8'd32;
  localparam logic [7:0] ByteCaretOfs = 8'd64;
  localparam logic [7:0] ByteDelete   = 8'd127;
  localparam logic [7:0] ByteHighBase = 8'd128;
  localparam logic [7:0] ByteMetaPrint = 8'd160;
  localparam logic [7:0] ByteMetaDel  = 8'd255;

  // Saturation value of the line counter in packed BCD, least significant
  // digit in the low nibble. Evaluated at elaboration only.
  function automatic logic [BcdW-1:0] cap_bcd();
    logic [BcdW-1:0]  r;
    longint unsigned  p;
    longint unsigned  lim;
    int               i;
    p   = 1;
    lim = (longint'(1) << CountMaxBits) - 1;
    for (i = 0; i < NumDigits; i++) begin
      p = p * 10;
    end
    p = p - 1;
    if (p > lim) begin
      p = lim;
    end
    r = '0;
    for (i = 0; i < NumDigits; i++) begin
      r[4*i +: 4] = 4'(p % 10);
      p = p / 10;
    end
    return r;
  endfunction

  localparam logic [BcdW-1:0] CountCap = cap_bcd();
  localparam logic [BcdW-1:0] CountOne = BcdW'(1);

  typedef struct packed {
    logic [1:0] number_mode;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprinting;
    logic       squeeze_blank;
  } cfg_t;

  // One classified request: optional number, optional dollar, then glyph bytes.
  typedef struct packed {
    logic            num;
    logic [BcdW-1:0] digits;
    logic            dol;
    logic [3:0][7:0] chars;
    logic [1:0]      char_last;
  } entry_t;

  typedef enum logic [1:0] {
    SEG_NUM,
    SEG_DOL,
    SEG_CHR
  } seg_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== design/text_stream_visualizer.sv =====
// ----------------------------------------------------------------------------
// Text stream visualizer
// Line numbering, blank squeezing and visible rendering of a text byte stream.
// ----------------------------------------------------------------------------
// The block takes one text byte per request and produces the bytes that a
// line-numbering, show-all text viewer would print for it, each marked with
// last on the final byte of its request; a request may produce no byte at all
// when a squeezed blank line is dropped. The front end accepts one request in
// every cycle as long as the four-entry request queue has room, and it keeps
// the line state (a decimal line counter that saturates at 999999, the
// after-newline flag and the newline run length) so that numbering decisions
// never wait on the output side. The back end writes exactly one byte per
// cycle into the output register unless the output stalls; a request yields
// one byte for a plain byte, two for caret forms, up to four for M- forms,
// plus seven for a line number and tab and one for a dollar sign, eleven at
// most. Sustained rate is one request per cycle for plain text unless the
// output stalls; expanding requests are absorbed by the queue and then hold
// off the input through in_stall_o. When the queue is empty, an accepted
// request goes into the queue and its first byte is then loaded from the
// queue head into the output register. The user must write configuration
// through the register port only while the block is idle (not enforced);
// cfg_ready_o is always high and writes to unused indexes are ignored.
`default_nettype none

`include "text_stream_visualizer_assert.svh"

module text_stream_visualizer (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [7:0]                    data_byte_i,
  input  wire                           file_start_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          last_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [tsv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [tsv_pkg::CfgDataW-1:0]  cfg_data_i
);

  tsv_pkg::cfg_t       cfg_q;
  tsv_pkg::entry_t     push_entry;
  tsv_pkg::entry_t     head_entry;
  tsv_pkg::q_status_t  q_stat;
  logic                push;
  logic                pop;

  assign cfg_ready_o = 1'b1;

  // Register writes; bits above each register's width are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tsv_pkg::cfg_reg_e'(cfg_index_i))
        tsv_pkg::REG_NUMBER_MODE:      cfg_q.number_mode      <= cfg_data_i[1:0];
        tsv_pkg::REG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data_i[0];
        tsv_pkg::REG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data_i[0];
        tsv_pkg::REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data_i[0];
        tsv_pkg::REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classifies each byte and updates the line state.
  tsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .q_full_i     (q_stat.full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Request queue that decouples the two ends.
  tsv_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_stat)
  );

  // Back end: spells out the head request one byte per cycle unless stalled.
  tsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .empty_i     (q_stat.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  // The back end must never retire a request that is not there.
  `TSV_ASSERT_NEVER(a_pop_when_empty, q_stat.pop && q_stat.empty, "pop from empty queue")
  // The front end must never write into a full queue.
  `TSV_ASSERT_NEVER(a_push_when_full, q_stat.push && q_stat.full, "push into full queue")
  // With nothing queued and nothing held, no byte can appear in the next cycle.
  `TSV_ASSERT(a_no_phantom_out, (!out_valid_o && q_stat.empty) |=> !out_valid_o,
              "output byte without a queued request")

endmodule

`default_nettype wire

// ===== design/tsv_front.sv =====
// ----------------------------------------------------------------------------
// Text stream visualizer front end
// Accepts input bytes, tracks line state and classifies each request.
// ----------------------------------------------------------------------------
`default_nettype none

module tsv_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  tsv_pkg::cfg_t          cfg_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [7:0]             data_byte_i,
  input  wire                    file_start_i,
  input  wire                    q_full_i,
  output logic                   push_o,
  output tsv_pkg::entry_t        entry_o
);

  logic [tsv_pkg::BcdW-1:0] count_q, count_d;
  logic                     prev_nl_q, prev_nl_d;
  logic [1:0]               run_q, run_d;

  logic                     accept;
  logic                     is_nl;
  logic                     drop;
  logic                     num;
  logic                     base_prev_nl;
  logic [tsv_pkg::BcdW-1:0] base_count;
  logic [1:0]               base_run;
  logic [tsv_pkg::BcdW-1:0] count_inc;
  logic                     carry;
  logic [7:0]               c;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign c          = data_byte_i;
  assign is_nl      = (c == tsv_pkg::ByteNewline);

  // A file start acts as if the state had just been reset.
  assign base_prev_nl = file_start_i ? 1'b1 : prev_nl_q;
  assign base_count   = file_start_i ? tsv_pkg::CountOne : count_q;
  assign base_run     = file_start_i ? 2'd1 : run_q;

  // Decimal increment, one digit at a time from the low end.
  always_comb begin
    count_inc = base_count;
    carry     = 1'b1;
    for (int k = 0; k < tsv_pkg::NumDigits; k++) begin
      if (carry) begin
        if (base_count[4*k +: 4] == 4'd9) begin
          count_inc[4*k +: 4] = 4'd0;
        end else begin
          count_inc[4*k +: 4] = base_count[4*k +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_comb begin
    run_d = base_run;
    if (cfg_i.squeeze_blank) begin
      if (is_nl) begin
        if (base_run != tsv_pkg::RunMax) begin
          run_d = base_run + 2'd1;
        end
      end else begin
        run_d = 2'd0;
      end
    end
    drop = is_nl & cfg_i.squeeze_blank & (run_d == tsv_pkg::RunMax);

    if (is_nl) begin
      num = ~drop & base_prev_nl & (cfg_i.number_mode == tsv_pkg::NumModeAll);
    end else begin
      num = base_prev_nl & (cfg_i.number_mode != tsv_pkg::NumModeOff);
    end

    count_d = base_count;
    if (num && (base_count != tsv_pkg::CountCap)) begin
      count_d = count_inc;
    end
    prev_nl_d = is_nl;
  end

  // Request classification and glyph rendering of the byte itself.
  always_comb begin
    entry_o.num       = num;
    entry_o.digits    = base_count;
    entry_o.dol       = is_nl & cfg_i.show_ends;
    entry_o.chars     = '0;
    entry_o.char_last = 2'd0;
    entry_o.chars[0]  = c;
    if (cfg_i.show_nonprinting && (c < tsv_pkg::ByteCtrlEnd) &&
        (c != tsv_pkg::ByteTab) && !is_nl) begin
      entry_o.chars[0]  = tsv_pkg::ByteCaret;
      entry_o.chars[1]  = c + tsv_pkg::ByteCaretOfs;
      entry_o.char_last = 2'd1;
    end else if (cfg_i.show_nonprinting && (c == tsv_pkg::ByteDelete)) begin
      entry_o.chars[0]  = tsv_pkg::ByteCaret;
      entry_o.chars[1]  = tsv_pkg::ByteQuestion;
      entry_o.char_last = 2'd1;
    end else if (cfg_i.show_nonprinting && (c >= tsv_pkg::ByteHighBase)) begin
      entry_o.chars[0] = tsv_pkg::ByteM;
      entry_o.chars[1] = tsv_pkg::ByteDash;
      if (c < tsv_pkg::ByteMetaPrint) begin
        entry_o.chars[2]  = tsv_pkg::ByteCaret;
        entry_o.chars[3]  = c - tsv_pkg::ByteCaretOfs;
        entry_o.char_last = 2'd3;
      end else if (c == tsv_pkg::ByteMetaDel) begin
        entry_o.chars[2]  = tsv_pkg::ByteCaret;
        entry_o.chars[3]  = tsv_pkg::ByteQuestion;
        entry_o.char_last = 2'd3;
      end else begin
        entry_o.chars[2]  = c - tsv_pkg::ByteHighBase;
        entry_o.char_last = 2'd2;
      end
    end else if ((c == tsv_pkg::ByteTab) && cfg_i.show_tabs) begin
      entry_o.chars[0]  = tsv_pkg::ByteCaret;
      entry_o.chars[1]  = tsv_pkg::ByteI;
      entry_o.char_last = 2'd1;
    end
  end

  assign push_o = accept & ~drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= tsv_pkg::CountOne;
      prev_nl_q <= 1'b1;
      run_q     <= 2'd1;
    end else if (accept) begin
      count_q   <= count_d;
      prev_nl_q <= prev_nl_d;
      run_q     <= run_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/tsv_queue.sv =====
// ----------------------------------------------------------------------------
// Text stream visualizer request queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tsv_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  tsv_pkg::entry_t     entry_i,
  input  wire                 pop_i,
  output tsv_pkg::entry_t     head_o,
  output tsv_pkg::q_status_t  status_o
);

  tsv_pkg::entry_t             mem_q [tsv_pkg::QueueDepth];
  logic [tsv_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [tsv_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                        full;
  logic                        empty;

  assign full   = (cnt_q == tsv_pkg::QCntW'(tsv_pkg::QueueDepth));
  assign empty  = (cnt_q == '0);
  assign head_o = mem_q[rd_ptr_q];

  assign status_o.push  = push_i;
  assign status_o.pop   = pop_i;
  assign status_o.full  = full;
  assign status_o.empty = empty;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/tsv_back.sv =====
// ----------------------------------------------------------------------------
// Text stream visualizer back end
// Expands one queued request into output bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tsv_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  tsv_pkg::entry_t     entry_i,
  input  wire                 empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_o
);

  tsv_pkg::seg_e               seg_q, seg_d, seg_eff;
  logic [tsv_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                        out_valid_q;
  logic [7:0]                  out_byte_q;
  logic                        out_last_q;

  logic                        load;
  logic [7:0]                  cur_byte;
  logic                        cur_last;
  logic [7:0]                  num_bytes [tsv_pkg::NumDigits + 1];
  logic                        seen;
  logic [3:0]                  digit;

  assign load = ~empty_i & (~out_valid_q | ~out_stall_i);

  // Number field: leading zeros become spaces, the units digit always shows.
  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < tsv_pkg::NumDigits; j++) begin
      digit = entry_i.digits[4*(tsv_pkg::NumDigits-1-j) +: 4];
      seen  = seen | (digit != 4'd0) | (j == tsv_pkg::NumDigits - 1);
      num_bytes[j] = seen ? (tsv_pkg::ByteZero + {4'd0, digit}) : tsv_pkg::ByteSpace;
    end
    num_bytes[tsv_pkg::NumDigits] = tsv_pkg::ByteTab;
  end

  always_comb begin
    seg_eff = seg_q;
    if ((seg_eff == tsv_pkg::SEG_NUM) && !entry_i.num) begin
      seg_eff = tsv_pkg::SEG_DOL;
    end
    if ((seg_eff == tsv_pkg::SEG_DOL) && !entry_i.dol) begin
      seg_eff = tsv_pkg::SEG_CHR;
    end

    cur_byte = entry_i.chars[idx_q[1:0]];
    cur_last = 1'b0;
    seg_d    = seg_q;
    idx_d    = idx_q;
    unique case (seg_eff)
      tsv_pkg::SEG_NUM: begin
        cur_byte = tsv_pkg::ByteTab;
        for (int j = 0; j < tsv_pkg::NumDigits; j++) begin
          if (idx_q == tsv_pkg::IdxW'(j)) begin
            cur_byte = num_bytes[j];
          end
        end
        if (idx_q == tsv_pkg::IdxW'(tsv_pkg::NumDigits)) begin
          seg_d = tsv_pkg::SEG_DOL;
          idx_d = '0;
        end else begin
          seg_d = tsv_pkg::SEG_NUM;
          idx_d = idx_q + 1'b1;
        end
      end
      tsv_pkg::SEG_DOL: begin
        cur_byte = tsv_pkg::ByteDollar;
        seg_d    = tsv_pkg::SEG_CHR;
        idx_d    = '0;
      end
      tsv_pkg::SEG_CHR: begin
        if (idx_q[1:0] == entry_i.char_last) begin
          cur_last = 1'b1;
          seg_d    = tsv_pkg::SEG_NUM;
          idx_d    = '0;
        end else begin
          seg_d = tsv_pkg::SEG_CHR;
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        seg_d = tsv_pkg::SEG_NUM;
        idx_d = '0;
      end
    endcase
  end

  assign pop_o = load & cur_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= tsv_pkg::SEG_NUM;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      seg_q       <= seg_d;
      idx_q       <= idx_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= cur_byte;
      out_last_q <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire
